@@ rtl/lru_tag_directory_unit_macros.svh @@
// ----------------------------------------------------------------------------
// lru_tag_directory_unit_macros.svh
// Assertion macros shared by the tag directory RTL.
// ----------------------------------------------------------------------------
`ifndef LRU_TAG_DIRECTORY_UNIT_MACROS_SVH
`define LRU_TAG_DIRECTORY_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define LTD_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define LTD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/ltd_pkg.sv @@
// ----------------------------------------------------------------------------
// ltd_pkg
// Types and constants for the LRU tag directory.
// ----------------------------------------------------------------------------
package ltd_pkg;

  // Directory geometry.
  localparam int SLOTS    = 8;
  localparam int TAG_BITS = 16;
  localparam int SLOT_W   = $clog2(SLOTS);
  localparam int CNT_W    = $clog2(SLOTS + 1);
  localparam int STAMP_W  = 32;
  localparam int STAT_W   = 32;

  // One request item.
  typedef struct packed {
    logic [15:0] tag;
    logic        fill_ok;
  } req_t;

  // One result item.
  typedef struct packed {
    logic        ok;
    logic        hit;
    logic [2:0]  slot;
    logic        evicted;
    logic [15:0] evicted_tag;
    logic [3:0]  resident_count;
    logic [3:0]  peak_resident;
    logic [31:0] request_count;
    logic [31:0] hit_count;
    logic [31:0] miss_count;
    logic [31:0] eviction_count;
  } rsp_t;

  // One directory entry as held in the slot memory.
  typedef struct packed {
    logic [TAG_BITS-1:0] tag;
    logic [STAMP_W-1:0]  stamp;
  } slot_entry_t;

endpackage

@@ rtl/lru_tag_directory_unit.sv @@
// ----------------------------------------------------------------------------
// lru_tag_directory_unit
// Fully associative tag directory with timestamp LRU replacement.
// ----------------------------------------------------------------------------
//
//   channel | signals                  | direction | carries
//   --------+--------------------------+-----------+-----------------------
//   req     | req_valid, req_stall, req| in        | tag, fill_ok
//   rsp     | rsp_valid, rsp_stall, rsp| out       | status and statistics
//
// An item passes an accept step, a scan of every slot in turn through the
// single read port of the slot memory, and an update step.
// Tag and stamp live in that memory; valid bits and counters are flip-flops.
// Reset empties the directory at once and clears all statistics.
// A stalled result waits in the output register; the next item may be
// accepted meanwhile, and its update holds until the register is free.
// ----------------------------------------------------------------------------
`include "lru_tag_directory_unit_macros.svh"

module lru_tag_directory_unit (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  ltd_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output ltd_pkg::rsp_t rsp
);
  import ltd_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_UPDATE
  } state_t;

  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(SLOTS - 1);

  state_t              state;
  logic [SLOTS-1:0]    slot_valid;
  logic [STAMP_W-1:0]  use_clock;
  logic [STAT_W-1:0]   requests_total;
  logic [STAT_W-1:0]   hits_total;
  logic [STAT_W-1:0]   misses_total;
  logic [STAT_W-1:0]   evictions_total;
  logic [CNT_W-1:0]    resident;
  logic [CNT_W-1:0]    peak_valid;

  // Per-item working registers.
  logic [TAG_BITS-1:0] want;
  logic                fill;
  logic                wrap;
  logic [SLOT_W-1:0]   idx;
  logic                hit_found;
  logic [SLOT_W-1:0]   hit_idx;
  logic                vic_free;
  logic [SLOT_W-1:0]   vic_idx;
  logic [STAMP_W-1:0]  vic_stamp;
  logic [TAG_BITS-1:0] vic_tag;

  // Slot memory and its ports.
  slot_entry_t         slot_mem [SLOTS];
  slot_entry_t         rd_entry;
  logic [SLOT_W-1:0]   rd_addr;
  logic                wr_en;
  logic [SLOT_W-1:0]   wr_addr;
  slot_entry_t         wr_entry;

  // Derived values for the scan and update steps.
  logic                cur_valid;
  logic                restamp;
  logic [STAMP_W-1:0]  stamp_eff;
  logic                rsp_free;
  logic                evict;
  logic                miss_fill;
  logic [SLOT_W-1:0]   chosen;
  logic [CNT_W-1:0]    resident_next;
  logic [CNT_W-1:0]    peak_next;
  logic [STAT_W-1:0]   requests_next;
  logic [STAT_W-1:0]   hits_next;
  logic [STAT_W-1:0]   misses_next;
  logic [STAT_W-1:0]   evictions_next;

  assign req_stall = (state != ST_IDLE);
  assign rsp_free  = !rsp_valid || !rsp_stall;

  // Slot memory: one registered read port, one write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      slot_mem[wr_addr] <= wr_entry;
    end
    rd_entry <= slot_mem[rd_addr];
  end

  // The scan reads the next slot while the current one is examined.
  always_comb begin
    if (state == ST_SCAN && idx != LAST_SLOT) begin
      rd_addr = idx + 1'b1;
    end else begin
      rd_addr = '0;
    end
  end

  // Scan step: a clock wrap renumbers each valid slot as it passes.
  assign cur_valid = slot_valid[idx];
  assign restamp   = (state == ST_SCAN) && wrap && cur_valid;
  assign stamp_eff = restamp ? use_clock : rd_entry.stamp;

  // Outcome of the finished scan.
  assign evict     = !hit_found && !vic_free;
  assign miss_fill = !hit_found && fill;
  assign chosen    = hit_found ? hit_idx : vic_idx;

  always_comb begin
    resident_next  = resident + CNT_W'(miss_fill) - CNT_W'(evict);
    peak_next      = (resident_next > peak_valid) ? resident_next : peak_valid;
    requests_next  = requests_total + 1'b1;
    hits_next      = hits_total + STAT_W'(hit_found);
    misses_next    = misses_total + STAT_W'(!hit_found);
    evictions_next = evictions_total + STAT_W'(evict);
  end

  // Memory writes: restamps during the scan, the hit or fill at update.
  always_comb begin
    wr_en    = 1'b0;
    wr_addr  = idx;
    wr_entry = '{tag: rd_entry.tag, stamp: use_clock};
    if (restamp) begin
      wr_en = 1'b1;
    end else if (state == ST_UPDATE && rsp_free) begin
      wr_en    = hit_found || fill;
      wr_addr  = chosen;
      wr_entry = '{tag: want, stamp: use_clock};
    end
  end

  // Sequencer, directory state and result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_IDLE;
      rsp_valid       <= 1'b0;
      slot_valid      <= '0;
      use_clock       <= '0;
      requests_total  <= '0;
      hits_total      <= '0;
      misses_total    <= '0;
      evictions_total <= '0;
      resident        <= '0;
      peak_valid      <= '0;
    end else begin
      // The update step reloads the result register itself.
      if (rsp_valid && !rsp_stall && state != ST_UPDATE) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (req_valid) begin
            want      <= TAG_BITS'(req.tag);
            fill      <= req.fill_ok;
            wrap      <= &use_clock;
            use_clock <= (&use_clock) ? STAMP_W'(1) : use_clock + 1'b1;
            idx       <= '0;
            hit_found <= 1'b0;
            vic_free  <= 1'b0;
            state     <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (restamp) begin
            use_clock <= use_clock + 1'b1;
          end
          // First valid slot holding the tag is the hit.
          if (!hit_found && cur_valid && rd_entry.tag == want) begin
            hit_found <= 1'b1;
            hit_idx   <= idx;
          end
          // Victim: first free slot, else lowest stamp with the lowest slot on ties.
          if (!vic_free) begin
            if (!cur_valid) begin
              vic_free <= 1'b1;
              vic_idx  <= idx;
            end else if (idx == '0 || stamp_eff < vic_stamp) begin
              vic_idx   <= idx;
              vic_stamp <= stamp_eff;
              vic_tag   <= rd_entry.tag;
            end
          end
          if (idx == LAST_SLOT) begin
            state <= ST_UPDATE;
          end else begin
            idx <= idx + 1'b1;
          end
        end
        ST_UPDATE: begin
          if (rsp_free) begin
            if (!hit_found) begin
              slot_valid[vic_idx] <= fill;
            end
            requests_total  <= requests_next;
            hits_total      <= hits_next;
            misses_total    <= misses_next;
            evictions_total <= evictions_next;
            resident        <= resident_next;
            peak_valid      <= peak_next;

            rsp_valid          <= 1'b1;
            rsp.ok             <= hit_found || fill;
            rsp.hit            <= hit_found;
            rsp.slot           <= 3'(chosen);
            rsp.evicted        <= evict;
            rsp.evicted_tag    <= evict ? 16'(vic_tag) : 16'd0;
            rsp.resident_count <= 4'(resident_next);
            rsp.peak_resident  <= 4'(peak_next);
            rsp.request_count  <= requests_next;
            rsp.hit_count      <= hits_next;
            rsp.miss_count     <= misses_next;
            rsp.eviction_count <= evictions_next;
            state              <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // The resident count tracks the valid bits.
  `LTD_ASSERT_NOW(a_resident_matches, clk, rst, 1'b1, resident == CNT_W'($countones(slot_valid)), "resident count disagrees with valid bits")

  // The peak never falls below the current count.
  `LTD_ASSERT_NOW(a_peak_bound, clk, rst, 1'b1, peak_valid >= resident, "peak below resident count")

  // The update holds while a stalled result occupies the output register.
  `LTD_ASSERT_NEXT(a_update_holds, clk, rst, state == ST_UPDATE && rsp_valid && rsp_stall, state == ST_UPDATE, "update overwrote a stalled result")

  // The use clock is never zero while slots are being scanned.
  `LTD_ASSERT_NOW(a_clock_nonzero, clk, rst, state == ST_SCAN, use_clock != '0, "use clock zero during scan")

endmodule
